// ----- design/swm_pkg.sv -----
// ----------------------------------------------------------------------------
// swm_pkg: shared types and constants of the sliding window median filter
// window limits, field widths, register map and cell link structs
// ----------------------------------------------------------------------------
package swm_pkg;

   localparam int MAX_WINDOW = 64;
   localparam int AGE_W      = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;
   localparam int CNT_W      = $clog2(MAX_WINDOW + 1);
   localparam int SAMPLE_W   = 32;
   localparam int MED_W      = SAMPLE_W + 1;
   localparam int WIN_W      = 7;
   localparam int RSP_DATA_W = ((MED_W + 7) / 8) * 8;
   localparam int ADDR_W     = 3;
   localparam int CSR_W      = 32;

   localparam logic [WIN_W-1:0] WINDOW_RESET = WIN_W'(3);
   localparam logic             REG_WINDOW_SIZE = 1'b0;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic [AGE_W-1:0]           age;
   } raw_type;

   typedef struct packed {
      logic signed [SAMPLE_W-1:0] value;
      logic [AGE_W-1:0]           age;
      logic                       keep;
   } fwd_type;

   typedef struct packed {
      logic                       step;
      logic                       full;
      logic signed [SAMPLE_W-1:0] sample;
      logic signed [SAMPLE_W-1:0] v_old;
   } ctl_type;

   function automatic logic [CNT_W-1:0] eff_size(input logic [WIN_W-1:0] w);
      logic [CNT_W-1:0] k;
      if (w == '0) begin
         k = CNT_W'(1);
      end else if (int'(w) > MAX_WINDOW) begin
         k = CNT_W'(MAX_WINDOW);
      end else begin
         k = CNT_W'(w);
      end
      return k;
   endfunction

endpackage

// ----- design/swm_cell.sv -----
// ----------------------------------------------------------------------------
// swm_cell: one slot of the sorted window chain
// holds a sample and its age; drops the oldest and inserts the new sample
// together with its neighbors in the same cycle
// ----------------------------------------------------------------------------
module swm_cell (
   input  logic             clock,
   input  swm_pkg::ctl_type ctl,
   input  logic             valid,
   input  logic             kept_valid,
   input  swm_pkg::raw_type above,
   input  swm_pkg::fwd_type below,
   output swm_pkg::raw_type cur,
   output swm_pkg::fwd_type fwd
);

   logic signed [swm_pkg::SAMPLE_W-1:0] value_ff, value_in;
   logic [swm_pkg::AGE_W-1:0]           age_ff, age_in;
   logic                                shift_down;

   // cell sits at or above the removed entry
   assign shift_down = ctl.full && (!valid || (value_ff >= ctl.v_old));

   always_comb begin
      fwd.value = shift_down ? above.value : value_ff;
      fwd.age   = shift_down ? above.age : age_ff;
      fwd.keep  = kept_valid && (fwd.value <= ctl.sample);
   end

   always_comb begin
      priority if (fwd.keep) begin
         value_in = fwd.value;
         age_in   = fwd.age + swm_pkg::AGE_W'(1);
      end else if (below.keep) begin
         value_in = ctl.sample;
         age_in   = '0;
      end else begin
         value_in = below.value;
         age_in   = below.age + swm_pkg::AGE_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.step) begin
         value_ff <= value_in;
         age_ff   <= age_in;
      end
   end

   assign cur.value = value_ff;
   assign cur.age   = age_ff;

endmodule

// ----- design/sliding_window_median.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median: running median over a window of signed samples
//
// req channel carries one sample per item, req_tlast ends a sequence and
// empties the window afterwards. once the window holds window_size samples
// (0 acts as 1, above 64 as 64), every item gives one rsp item: twice the
// window median (sum of the two middle values for an even size, double the
// middle for an odd size), with rsp_tlast copied from the sample that caused
// it. items that only fill the window give no result.
// a row of sorted cells drops the oldest sample and inserts the new one in
// the cycle an item is accepted; the median is then picked from the cells
// into the output register once that register is free. throughput is one
// item per cycle while rsp_tready stays high.
// when the receiver stalls, one result waits in the output register and one
// more in the median stage; req_tready then drops until space frees up.
// reset empties the window and sets window_size to 3. writing window_size
// over the csr port also empties the window.
// ----------------------------------------------------------------------------
module sliding_window_median (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [swm_pkg::SAMPLE_W-1:0]      req_tdata,   // sample
   input  logic                              req_tlast,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [swm_pkg::RSP_DATA_W-1:0]    rsp_tdata,   // twice_median, zero pad
   output logic                              rsp_tlast,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [swm_pkg::ADDR_W-1:0]        csr_paddr,
   input  logic [swm_pkg::CSR_W-1:0]         csr_pwdata,
   output logic [swm_pkg::CSR_W-1:0]         csr_prdata,
   output logic                              csr_pready
);

   localparam int N = swm_pkg::MAX_WINDOW;

   logic [swm_pkg::WIN_W-1:0]        window_ff, window_in;
   logic [swm_pkg::CNT_W-1:0]        fill_ff, fill_in;
   logic                             pend_ff, pend_in;
   logic                             pend_last_ff, pend_last_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic signed [swm_pkg::MED_W-1:0] rsp_data_ff, rsp_data_in;
   logic                             rsp_last_ff, rsp_last_in;

   logic                             csr_wr, csr_sel_win;
   logic                             accept, rsp_free, full, produce;
   logic [swm_pkg::CNT_W-1:0]        k, kept_cnt;
   logic [swm_pkg::AGE_W-1:0]        k_last_age, hi_idx, lo_idx;
   swm_pkg::ctl_type                 ctl;
   swm_pkg::raw_type                 raw [N];
   swm_pkg::fwd_type                 fwd [N];
   logic [N-1:0]                     valid, kept_valid;
   logic signed [swm_pkg::SAMPLE_W-1:0] v_old;

   // csr port
   assign csr_pready  = 1'b1;
   assign csr_sel_win = (csr_paddr[2] == swm_pkg::REG_WINDOW_SIZE);
   assign csr_wr      = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_prdata  = csr_sel_win ? swm_pkg::CSR_W'(window_ff) : '0;
   assign window_in   = (csr_wr && csr_sel_win) ? csr_pwdata[swm_pkg::WIN_W-1:0] : window_ff;

   // window control
   assign k          = swm_pkg::eff_size(window_ff);
   assign k_last_age = swm_pkg::AGE_W'(k - swm_pkg::CNT_W'(1));
   assign full       = (fill_ff == k);
   assign kept_cnt   = fill_ff - swm_pkg::CNT_W'(full);
   assign produce    = full || ((fill_ff + swm_pkg::CNT_W'(1)) == k);

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = !pend_ff || rsp_free;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      v_old = '0;
      for (int i = 0; i < N; i++) begin
         valid[i]      = fill_ff > swm_pkg::CNT_W'(i);
         kept_valid[i] = kept_cnt > swm_pkg::CNT_W'(i);
         if (valid[i] && (raw[i].age == k_last_age)) begin
            v_old = v_old | raw[i].value;
         end
      end
   end

   assign ctl.step   = accept;
   assign ctl.full   = full;
   assign ctl.sample = req_tdata;
   assign ctl.v_old  = v_old;

   // cell chain
   for (genvar i = 0; i < N; i++) begin : g_cell
      swm_pkg::raw_type above;
      swm_pkg::fwd_type below;
      if (i == N - 1) begin : g_top
         assign above = '0;
      end else begin : g_mid
         assign above = raw[i+1];
      end
      if (i == 0) begin : g_bot
         assign below = '{value: '0, age: '0, keep: 1'b1};
      end else begin : g_up
         assign below = fwd[i-1];
      end
      swm_cell u_cell (
         .clock      (clock),
         .ctl        (ctl),
         .valid      (valid[i]),
         .kept_valid (kept_valid[i]),
         .above      (above),
         .below      (below),
         .cur        (raw[i]),
         .fwd        (fwd[i])
      );
   end

   // median pick from the settled cells
   assign hi_idx = swm_pkg::AGE_W'(k >> 1);
   assign lo_idx = k[0] ? hi_idx : (hi_idx - swm_pkg::AGE_W'(1));

   always_comb begin
      fill_in = fill_ff;
      if (accept) begin
         if (req_tlast) begin
            fill_in = '0;
         end else if (!full) begin
            fill_in = fill_ff + swm_pkg::CNT_W'(1);
         end
      end
      if (csr_wr && csr_sel_win) begin
         fill_in = '0;
      end
   end

   always_comb begin
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_free) begin
         rsp_valid_in = pend_ff;
         rsp_data_in  = swm_pkg::MED_W'(raw[lo_idx].value) +
                        swm_pkg::MED_W'(raw[hi_idx].value);
         rsp_last_in  = pend_last_ff;
         pend_in      = 1'b0;
      end
      if (accept) begin
         pend_in      = produce;
         pend_last_in = req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff    <= swm_pkg::WINDOW_RESET;
         fill_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         window_ff    <= window_in;
         fill_ff      <= fill_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_last_ff <= pend_last_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = swm_pkg::RSP_DATA_W'(unsigned'(rsp_data_ff));
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- bench/sliding_window_median_tb.sv -----
// ----------------------------------------------------------------------------
// sliding_window_median_tb: self-checking bench for the running median filter
//
// a scoreboard class tracks the window in arrival order plus a sorted copy,
// predicts twice the median for every accepted sample once the window is
// full, and checks each rsp item in order. stimulus starts with edge values,
// short sequences and repeated samples, then runs random sequences over a
// range of window sizes (zero and above the maximum among them) while the
// sender bursts and the receiver stalls in changing patterns.
// ----------------------------------------------------------------------------
module sliding_window_median_tb;

   localparam int SETTLE_CYCLES = 6;
   localparam int IDLE_LIMIT    = 5000;
   localparam int NUM_PHASES    = 10;
   localparam int PHASE_WIN [NUM_PHASES]   = '{1, 0, 2, 4, 64, 127, 5, 7, 6, 33};
   localparam int PHASE_ITEMS [NUM_PHASES] = '{60, 40, 70, 80, 150, 120, 80, 70, 60, 80};
   localparam logic signed [swm_pkg::SAMPLE_W-1:0] S_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [swm_pkg::SAMPLE_W-1:0] S_MIN = 32'sh8000_0000;

   typedef enum int {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_SPARSE} rx_mode_type;
   typedef enum int {SMP_FULL, SMP_NARROW, SMP_EDGE, SMP_MID} sample_kind_type;

   class median_scoreboard;
      typedef struct {
         logic [swm_pkg::MED_W-1:0] twice;
         logic                      last;
      } median_type;

      logic [swm_pkg::WIN_W-1:0]           window_size_reg;
      logic signed [swm_pkg::SAMPLE_W-1:0] arrival [swm_pkg::MAX_WINDOW];
      logic signed [swm_pkg::SAMPLE_W-1:0] ordered [$];
      int unsigned                         fill;
      int unsigned                         oldest;
      median_type                          expected_medians [$];
      int                                  errors;

      function new();
         window_size_reg = swm_pkg::WINDOW_RESET;
         errors = 0;
         clear_window();
      endfunction

      function void clear_window();
         fill = 0;
         oldest = 0;
         ordered.delete();
      endfunction

      function int unsigned span();
         if (window_size_reg == '0) return 1;
         if (int'(window_size_reg) > swm_pkg::MAX_WINDOW) return swm_pkg::MAX_WINDOW;
         return int'(window_size_reg);
      endfunction

      function int pending();
         return expected_medians.size();
      endfunction

      function void set_window(logic [swm_pkg::WIN_W-1:0] w);
         window_size_reg = w;
         clear_window();
      endfunction

      function void note_sample(logic signed [swm_pkg::SAMPLE_W-1:0] s, logic last);
         int unsigned                         k;
         int unsigned                         i;
         logic signed [swm_pkg::SAMPLE_W-1:0] lo;
         logic signed [swm_pkg::SAMPLE_W-1:0] hi;
         median_type                          m;
         k = span();
         if (fill > k || oldest >= k) clear_window();
         if (fill < k) begin
            arrival[fill] = s;
            fill++;
         end else begin
            // one cell equal to the leaving sample goes, even among duplicates
            for (int j = 0; j < ordered.size(); j++) begin
               if (ordered[j] == arrival[oldest]) begin
                  ordered.delete(j);
                  break;
               end
            end
            arrival[oldest] = s;
            oldest = (oldest + 1 >= k) ? 0 : oldest + 1;
         end
         i = ordered.size();
         while (i > 0 && ordered[i-1] > s) i--;
         ordered.insert(i, s);
         if (fill == k) begin
            hi = ordered[k/2];
            lo = (k % 2 == 1) ? hi : ordered[k/2 - 1];
            m.twice = {lo[swm_pkg::SAMPLE_W-1], lo} + {hi[swm_pkg::SAMPLE_W-1], hi};
            m.last = last;
            expected_medians.push_back(m);
         end
         if (last) clear_window();
      endfunction

      function void check_median(logic [swm_pkg::RSP_DATA_W-1:0] data, logic last);
         median_type m;
         if (expected_medians.size() == 0) begin
            $error("unexpected median item: twice_median %0d",
                   $signed(data[swm_pkg::MED_W-1:0]));
            errors++;
            return;
         end
         m = expected_medians.pop_front();
         if (data[swm_pkg::MED_W-1:0] !== m.twice) begin
            $error("twice_median: expected %0d, actual %0d",
                   $signed(m.twice), $signed(data[swm_pkg::MED_W-1:0]));
            errors++;
         end
         if (last !== m.last) begin
            $error("last_median: expected %0b, actual %0b", m.last, last);
            errors++;
         end
      endfunction
   endclass

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [swm_pkg::SAMPLE_W-1:0]     req_tdata = '0;      // sample
   logic                             req_tlast = 1'b0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [swm_pkg::RSP_DATA_W-1:0]   rsp_tdata;           // twice_median, zero pad
   logic                             rsp_tlast;
   logic                             csr_psel = 1'b0;
   logic                             csr_penable = 1'b0;
   logic                             csr_pwrite = 1'b0;
   logic [swm_pkg::ADDR_W-1:0]       csr_paddr = '0;
   logic [swm_pkg::CSR_W-1:0]        csr_pwdata = '0;
   logic [swm_pkg::CSR_W-1:0]        csr_prdata;
   logic                             csr_pready;

   median_scoreboard sb;
   int               idle_cycles = 0;
   int               burst_left = 0;
   rx_mode_type      rx_mode = RX_OPEN;
   int               rx_left = 0;
   int               rx_phase = 0;

   sliding_window_median u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         sb.note_sample(req_tdata, req_tlast);
      end
      if (!reset && rsp_tvalid && rsp_tready) begin
         sb.check_median(rsp_tdata, rsp_tlast);
      end
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
      end
   end

   always @(posedge clock) begin
      if (rx_left == 0) begin
         rx_mode = rx_mode_type'($urandom_range(0, 3));
         rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
         RX_OPEN:     rsp_tready <= 1'b1;
         RX_RANDOM:   rsp_tready <= ($urandom_range(0, 3) != 0);
         RX_PERIODIC: rsp_tready <= ((rx_phase % 7) < 3);
         default:     rsp_tready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("== FAIL ==");
      $finish;
   end

   function automatic logic signed [swm_pkg::SAMPLE_W-1:0] pick_sample(
         sample_kind_type kind);
      if ($urandom_range(0, 15) == 0) kind = SMP_EDGE;
      case (kind)
         SMP_NARROW: return $urandom_range(0, 8) - 4;
         SMP_MID:    return $urandom_range(0, 2000) - 1000;
         SMP_EDGE: begin
            case ($urandom_range(0, 4))
               0:       return S_MIN;
               1:       return S_MAX;
               2:       return -1;
               3:       return 0;
               default: return 1;
            endcase
         end
         default:    return $urandom;
      endcase
   endfunction

   task automatic send_item(input logic signed [swm_pkg::SAMPLE_W-1:0] s,
                            input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= s;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (sb.pending() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_window(input logic [swm_pkg::WIN_W-1:0] w);
      logic [swm_pkg::CSR_W-1:0] word;
      drain();
      word = $urandom;
      word[swm_pkg::WIN_W-1:0] = w;
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= swm_pkg::ADDR_W'(4 * int'(swm_pkg::REG_WINDOW_SIZE));
      csr_pwdata  <= word;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.set_window(w);
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata[swm_pkg::WIN_W-1:0] !== w) begin
         $error("window_size: expected %0d, actual %0d", w,
                csr_prdata[swm_pkg::WIN_W-1:0]);
         sb.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic run_phase(input logic [swm_pkg::WIN_W-1:0] w, input int budget);
      int unsigned     k;
      int              len;
      int              sent;
      sample_kind_type kind;
      set_window(w);
      k = sb.span();
      sent = 0;
      while (sent < budget) begin
         if (k > 1 && $urandom_range(0, 5) == 0) begin
            len = $urandom_range(1, k - 1);
         end else begin
            len = k + $urandom_range(0, k + 8);
         end
         kind = sample_kind_type'($urandom_range(0, 3));
         for (int n = 0; n < len; n++) begin
            send_item(pick_sample(kind), (n == len - 1) && ($urandom_range(0, 7) != 0));
         end
         sent += len;
         if ($urandom_range(0, 3) == 0) drain();
      end
   endtask

   initial begin
      sb = new();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window of three: extremes, short sequence, repeated samples
      send_item(S_MAX, 1'b0);
      send_item(S_MAX, 1'b0);
      send_item(S_MAX, 1'b0);
      send_item(S_MIN, 1'b0);
      send_item(S_MIN, 1'b0);
      send_item(S_MIN, 1'b0);
      send_item(0, 1'b0);
      send_item(-1, 1'b1);
      send_item(7, 1'b0);
      send_item(7, 1'b1);
      send_item(5, 1'b0);
      send_item(5, 1'b0);
      send_item(9, 1'b0);
      send_item(5, 1'b0);
      send_item(-3, 1'b0);
      send_item(5, 1'b1);

      set_window(2);
      send_item(S_MAX, 1'b0);
      send_item(S_MIN, 1'b0);
      send_item(S_MAX, 1'b0);
      send_item(S_MAX, 1'b1);

      set_window(1);
      send_item(S_MIN, 1'b0);
      send_item(-1, 1'b0);
      send_item(S_MAX, 1'b1);

      for (int p = 0; p < NUM_PHASES; p++) begin
         run_phase(swm_pkg::WIN_W'(PHASE_WIN[p]), PHASE_ITEMS[p]);
      end
      run_phase(swm_pkg::WIN_W'($urandom_range(8, 20)), 70);

      drain();
      if (sb.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
